// ----- hw/rtl/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants, types and helper functions for the bitmap id allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

    // Map geometry: MAP_WORDS words of 32 bits, one bit per id.
    localparam int MAP_WORDS = 128;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int WORD_W    = $clog2(MAP_WORDS);
    localparam int ID_W      = 12;
    localparam int IDW_W     = ID_W - BIT_W;

    typedef logic [WORD_W-1:0]    word_idx_t;
    typedef logic [BIT_W-1:0]     bit_idx_t;
    typedef logic [WORD_BITS-1:0] map_word_t;

    // Operation codes carried by an item.
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_RESERVE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic bit_idx_t lowest_set(input map_word_t v);
        bit_idx_t b;
        b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = BIT_W'(i);
            end
        end
        return b;
    endfunction

    // Next word index with wrap-around after the last word.
    function automatic word_idx_t next_word(input word_idx_t w);
        word_idx_t n;
        if (w == WORD_W'(MAP_WORDS - 1))
        begin
            n = '0;
        end
        else
        begin
            n = w + 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bia_ram.sv -----
// ----------------------------------------------------------------------------
// bia_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_id_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Allocates, releases and reserves ids held in a bitmap of free ids, with a
// roving word pointer that sets where the next allocation starts its scan.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Payload
//  --------  ------------------  ------------------------------
//  command   start && !busy      operation[1:0], id[11:0]
//  result    done (one cycle)    granted_id[11:0], status
//
//  An allocate reads one map word per cycle from the RAM, starting at the
//  pointer: busy stays high while it examines from 1 to MAP_WORDS words,
//  and done is registered from the last word examined.
//  Release and reserve do one read-modify-write.
//  An unknown operation or an id beyond the map gives done the next cycle.
//  After reset every word reads as all ones through per-word valid bits;
//  no clearing pass is needed. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             operation,
    input  wire logic [bia_pkg::ID_W-1:0] id,
    output logic                        done,
    output logic [bia_pkg::ID_W-1:0]    granted_id,
    output logic                        status
);

    import bia_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MOD
    } state_t;

    state_t             state_reg;
    op_t                op_reg;
    bit_idx_t           bit_reg;
    word_idx_t          cur_word_reg;
    word_idx_t          scan_word_reg;
    word_idx_t          scan_cnt_reg;
    logic               done_reg;
    logic [ID_W-1:0]    granted_reg;
    logic               status_reg;

    logic [MAP_WORDS-1:0] valid_reg;
    logic                 rd_valid_reg;

    logic               rd_en;
    word_idx_t          rd_addr;
    logic               wr_en;
    word_idx_t          wr_addr;
    map_word_t          wr_data;
    map_word_t          rd_data;
    map_word_t          word_data;
    bit_idx_t           low_bit;
    map_word_t          bit_mask;
    op_t                in_op;
    logic [IDW_W-1:0]   in_word;
    logic               in_range;
    logic               accept;
    logic               last_word;

    assign accept   = start && !busy;
    assign in_op    = op_t'(operation);
    assign in_word  = id[ID_W-1:BIT_W];
    assign in_range = (32'(in_word) < MAP_WORDS);

    // A word never written since reset reads as all ones.
    assign word_data = rd_valid_reg ? rd_data : '1;
    assign low_bit   = lowest_set(word_data);
    assign bit_mask  = map_word_t'(1) << ((state_reg == ST_SCAN) ? low_bit : bit_reg);
    assign last_word = (scan_cnt_reg == WORD_W'(MAP_WORDS - 1));

    // RAM access control for the scan and the read-modify-write.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = cur_word_reg;
        wr_data = word_data & ~bit_mask;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_en   = 1'b1;
                    rd_addr = (in_op == OP_ALLOC) ? scan_word_reg : WORD_W'(in_word);
                end
            end
            ST_SCAN:
            begin
                if (word_data != '0)
                begin
                    wr_en = 1'b1;
                end
                else if (!last_word)
                begin
                    rd_en   = 1'b1;
                    rd_addr = next_word(cur_word_reg);
                end
            end
            ST_MOD:
            begin
                wr_en = 1'b1;
                if (op_reg == OP_RELEASE)
                begin
                    wr_data = word_data | bit_mask;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    bia_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .ADDR_W(WORD_W)
    ) u_map_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Per-word valid bits, registered alongside the RAM read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Control state machine with the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            bit_reg       <= '0;
            cur_word_reg  <= '0;
            scan_word_reg <= '0;
            scan_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            granted_reg   <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= in_op;
                        bit_reg      <= id[BIT_W-1:0];
                        scan_cnt_reg <= '0;
                        unique case (in_op)
                            OP_ALLOC:
                            begin
                                cur_word_reg <= scan_word_reg;
                                state_reg    <= ST_SCAN;
                            end
                            OP_RELEASE,
                            OP_RESERVE:
                            begin
                                cur_word_reg <= WORD_W'(in_word);
                                if (in_range)
                                begin
                                    state_reg <= ST_MOD;
                                end
                                else
                                begin
                                    done_reg    <= 1'b1;
                                    granted_reg <= '0;
                                    status_reg  <= 1'b0;
                                end
                            end
                            OP_NONE:
                            begin
                                done_reg    <= 1'b1;
                                granted_reg <= '0;
                                status_reg  <= 1'b0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (word_data != '0)
                    begin
                        // Take the lowest free bit of this word.
                        done_reg    <= 1'b1;
                        granted_reg <= ID_W'({cur_word_reg, low_bit});
                        status_reg  <= 1'b0;
                        if (low_bit == BIT_W'(WORD_BITS - 1))
                        begin
                            scan_word_reg <= next_word(cur_word_reg);
                        end
                        else
                        begin
                            scan_word_reg <= cur_word_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else if (last_word)
                    begin
                        // Every word examined and none has a free bit.
                        done_reg    <= 1'b1;
                        granted_reg <= '0;
                        status_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        cur_word_reg <= next_word(cur_word_reg);
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                ST_MOD:
                begin
                    // A release below the pointer pulls the pointer back.
                    if (op_reg == OP_RELEASE && cur_word_reg < scan_word_reg)
                    begin
                        scan_word_reg <= cur_word_reg;
                    end
                    done_reg    <= 1'b1;
                    granted_reg <= '0;
                    status_reg  <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    // A result only follows an accepted item or work in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without an item in progress");

    // A map write closes the item: its result appears next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> done)
        else $error("map written without a result following");

    // A failed allocate leaves the map untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> !$past(wr_en))
        else $error("map written on a full-map failure");

    // Writes happen only while scanning or modifying.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_SCAN || state_reg == ST_MOD))
        else $error("map write outside an active item");
`endif

endmodule

`default_nettype wire
